[hw/rtl/imucal_pkg.sv]
package imucal_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int ATAN_LEN    = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HARD_OFFSET_X = 3'd0,
        REG_HARD_OFFSET_Y = 3'd1,
        REG_HARD_OFFSET_Z = 3'd2,
        REG_SOFT_GAIN_X   = 3'd3,
        REG_SOFT_GAIN_Y   = 3'd4,
        REG_SOFT_GAIN_Z   = 3'd5
    } cfg_index_t;

    localparam logic signed [12:0] HARD_OFFSET_X_RST = 13'sd370;
    localparam logic signed [12:0] HARD_OFFSET_Y_RST = -13'sd470;
    localparam logic signed [12:0] HARD_OFFSET_Z_RST = -13'sd5;
    localparam logic [15:0]        SOFT_GAIN_X_RST   = 16'd16384;
    localparam logic [15:0]        SOFT_GAIN_Y_RST   = 16'd15073;
    localparam logic [15:0]        SOFT_GAIN_Z_RST   = 16'd17695;

    localparam logic [15:0] HEADING_SCALE = 16'd36000;

    localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

endpackage

[hw/rtl/imu_calibrate_tilt_heading.sv]
// Data path: the bit-per-stage square root, the 15-stage divider and the CORDIC stages
// run in series.
// Throughput: one transaction per cycle; the whole pipeline holds while the output
// register is full and m_tready is low.
// Reset: aresetn is synchronous and active low; it empties the pipeline and loads the
// calibration registers with their default values.
module imu_calibrate_tilt_heading #(
    parameter int CORDIC_STAGES = 16,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [imucal_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [imucal_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, mag_x, mag_y, mag_z
    input  logic [((6*SAMPLE_BITS+39+7)/8)*8-1:0] s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // marine_accel_x/y/z, marine_rate_x/y/z, unit_mag_x/y/z, roll_angle,
    // pitch_angle, heading_centidegrees (16 bits each)
    output logic [191:0]                         m_tdata
);

    localparam int SB   = SAMPLE_BITS;
    localparam int VW   = 30;
    localparam int SQW  = 60;
    localparam int SQ_N = (SB + 16 > 30) ? SB + 16 : 30;
    localparam int RW   = SQ_N + 3;
    localparam int CW   = (SB + 19 > 34) ? SB + 19 : 34;
    localparam int CS   = CORDIC_STAGES;
    localparam int SQ0  = 3;
    localparam int D0   = SQ0 + SQ_N;
    localparam int UST  = D0 + 16;
    localparam int C0   = UST + 1;
    localparam int BST  = C0 + CS + 1;
    localparam int LAT  = BST + 2;

    typedef struct packed {
        logic [2*SQ_N-1:0] rad;
        logic [RW-1:0]     rem;
        logic [SQ_N-1:0]   root;
    } sq_t;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [31:0]   z;
        logic          zero;
    } cd_t;

    typedef struct packed {
        logic [5:0][15:0]   marine;
        logic [2:0][VW-1:0] v;
        logic [SB:0]        ny;
        logic [SB:0]        nz;
        logic [SB:0]        nax;
        logic [2:0][SQW-1:0] msq;
        logic [1:0][2*SB-1:0] hs;
        sq_t                ms;
        sq_t                hq;
        logic [SQ_N-1:0]    hsq;
        logic [29:0]        norm;
        logic               nzero;
        logic [2:0][43:0]   drem;
        logic [2:0][14:0]   q;
        logic [2:0]         neg;
        logic [2:0][15:0]   u;
        cd_t [2:0]          cd;
        logic [15:0]        roll;
        logic [15:0]        pitch;
        logic [47:0]        hprod;
        logic [15:0]        heading;
    } item_t;

    logic signed [12:0] hard_offset_x_reg, hard_offset_y_reg, hard_offset_z_reg;
    logic [15:0]        soft_gain_x_reg, soft_gain_y_reg, soft_gain_z_reg;

    logic [LAT-1:0] vld_reg;
    item_t          item_reg  [LAT];
    item_t          item_next [LAT];
    logic           adv;

    function automatic logic [15:0] lo16(input logic signed [SB:0] v);
        logic signed [SB+16:0] e;
        e = (SB+17)'(v);
        return e[15:0];
    endfunction

    function automatic logic signed [SB:0] neg_exact(input logic signed [SB-1:0] v);
        logic signed [SB:0] e;
        e = (SB+1)'(v);
        return -e;
    endfunction

    function automatic logic signed [SB:0] neg_sat(input logic signed [SB-1:0] v);
        logic signed [SB:0] r;
        r = neg_exact(v);
        if (v == {1'b1, {(SB-1){1'b0}}}) begin
            r = (SB+1)'({1'b0, {(SB-1){1'b1}}});
        end
        return r;
    endfunction

    function automatic logic [VW-1:0] corr(input logic signed [14:0] d, input logic [15:0] g);
        logic signed [31:0] p;
        p = 32'(d) * $signed({16'b0, g});
        return p[VW-1:0];
    endfunction

    function automatic logic [SQW-1:0] square(input logic [VW-1:0] v);
        logic signed [SQW-1:0] e;
        e = SQW'($signed(v));
        return e * e;
    endfunction

    function automatic logic [2*SB-1:0] hsquare(input logic [SB:0] v);
        logic signed [2*SB+1:0] e;
        logic signed [2*SB+1:0] p;
        e = (2*SB+2)'($signed(v));
        p = e * e;
        return p[2*SB-1:0];
    endfunction

    function automatic sq_t sqrt_step(input sq_t s);
        sq_t r;
        logic [RW-1:0] cur;
        logic [RW-1:0] trial;
        cur   = {s.rem[RW-3:0], s.rad[2*SQ_N-1 -: 2]};
        trial = RW'({s.root, 2'b01});
        r.rad = s.rad << 2;
        if (cur >= trial) begin
            r.rem  = cur - trial;
            r.root = {s.root[SQ_N-2:0], 1'b1};
        end else begin
            r.rem  = cur;
            r.root = {s.root[SQ_N-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic cd_t cd_init(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
        cd_t c;
        c.zero = (x == '0) && (y == '0);
        if (x < 0) begin
            c.x = -x;
            c.y = -y;
            c.z = 32'h8000_0000;
        end else begin
            c.x = x;
            c.y = y;
            c.z = '0;
        end
        return c;
    endfunction

    function automatic cd_t cd_step(input cd_t c, input int j, input logic [31:0] ang);
        cd_t r;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        x  = $signed(c.x);
        y  = $signed(c.y);
        dx = x >>> j;
        dy = y >>> j;
        r.zero = c.zero;
        if (y > 0) begin
            r.x = x + dy;
            r.y = y - dx;
            r.z = c.z + ang;
        end else begin
            r.x = x - dy;
            r.y = y + dx;
            r.z = c.z - ang;
        end
        return r;
    endfunction

    function automatic logic [15:0] bam16(input cd_t c);
        logic [31:0] t;
        t = c.z + 32'h0000_8000;
        return c.zero ? 16'd0 : t[31:16];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hard_offset_x_reg <= imucal_pkg::HARD_OFFSET_X_RST;
            hard_offset_y_reg <= imucal_pkg::HARD_OFFSET_Y_RST;
            hard_offset_z_reg <= imucal_pkg::HARD_OFFSET_Z_RST;
            soft_gain_x_reg   <= imucal_pkg::SOFT_GAIN_X_RST;
            soft_gain_y_reg   <= imucal_pkg::SOFT_GAIN_Y_RST;
            soft_gain_z_reg   <= imucal_pkg::SOFT_GAIN_Z_RST;
        end else if (cfg_we) begin
            case (imucal_pkg::cfg_index_t'(cfg_index))
                imucal_pkg::REG_HARD_OFFSET_X: hard_offset_x_reg <= cfg_data[12:0];
                imucal_pkg::REG_HARD_OFFSET_Y: hard_offset_y_reg <= cfg_data[12:0];
                imucal_pkg::REG_HARD_OFFSET_Z: hard_offset_z_reg <= cfg_data[12:0];
                imucal_pkg::REG_SOFT_GAIN_X:   soft_gain_x_reg   <= cfg_data;
                imucal_pkg::REG_SOFT_GAIN_Y:   soft_gain_y_reg   <= cfg_data;
                imucal_pkg::REG_SOFT_GAIN_Z:   soft_gain_z_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign adv      = !vld_reg[LAT-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    logic signed [SB-1:0] ax, ay, az, gx, gy, gz;
    logic signed [12:0]   mgx, mgy, mgz;
    logic signed [14:0]   dfx, dfy, dfz;

    assign ax  = s_tdata[0*SB +: SB];
    assign ay  = s_tdata[1*SB +: SB];
    assign az  = s_tdata[2*SB +: SB];
    assign gx  = s_tdata[3*SB +: SB];
    assign gy  = s_tdata[4*SB +: SB];
    assign gz  = s_tdata[5*SB +: SB];
    assign mgx = s_tdata[6*SB +: 13];
    assign mgy = s_tdata[6*SB+13 +: 13];
    assign mgz = s_tdata[6*SB+26 +: 13];

    assign dfx = 15'(mgx) - 15'(hard_offset_x_reg);
    assign dfy = -15'(mgy) - 15'(hard_offset_y_reg);
    assign dfz = 15'(mgz) - 15'(hard_offset_z_reg);

    always_comb begin
        item_next[0]           = '0;
        item_next[0].marine[0] = lo16((SB+1)'(ax));
        item_next[0].marine[1] = lo16(neg_sat(ay));
        item_next[0].marine[2] = lo16(neg_sat(az));
        item_next[0].marine[3] = lo16((SB+1)'(gx));
        item_next[0].marine[4] = lo16(neg_sat(gy));
        item_next[0].marine[5] = lo16(neg_sat(gz));
        item_next[0].ny        = neg_exact(ay);
        item_next[0].nz        = neg_exact(az);
        item_next[0].nax       = neg_exact(ax);
        item_next[0].v[0]      = corr(dfx, soft_gain_x_reg);
        item_next[0].v[1]      = corr(dfy, soft_gain_y_reg);
        item_next[0].v[2]      = corr(dfz, soft_gain_z_reg);
    end

    for (genvar i = 1; i < LAT; i++) begin : g_stage
        if (i == 1) begin : g_square
            always_comb begin
                item_next[i] = item_reg[i-1];
                for (int l = 0; l < 3; l++) begin
                    item_next[i].msq[l] = square(item_reg[i-1].v[l]);
                end
                item_next[i].hs[0] = hsquare(item_reg[i-1].ny);
                item_next[i].hs[1] = hsquare(item_reg[i-1].nz);
            end
        end else if (i == 2) begin : g_sum
            always_comb begin
                item_next[i]         = item_reg[i-1];
                item_next[i].ms.rad  = (2*SQ_N)'(item_reg[i-1].msq[0])
                                     + (2*SQ_N)'(item_reg[i-1].msq[1])
                                     + (2*SQ_N)'(item_reg[i-1].msq[2]);
                item_next[i].ms.rem  = '0;
                item_next[i].ms.root = '0;
                item_next[i].hq.rad  = ((2*SQ_N)'(item_reg[i-1].hs[0])
                                     + (2*SQ_N)'(item_reg[i-1].hs[1])) << 32;
                item_next[i].hq.rem  = '0;
                item_next[i].hq.root = '0;
            end
        end else if (i < D0) begin : g_sqrt
            always_comb begin
                item_next[i]    = item_reg[i-1];
                item_next[i].ms = sqrt_step(item_reg[i-1].ms);
                item_next[i].hq = sqrt_step(item_reg[i-1].hq);
            end
        end else if (i == D0) begin : g_div_prep
            logic [29:0] nrm;
            assign nrm = item_reg[i-1].ms.root[29:0];
            always_comb begin
                logic signed [VW-1:0] sv;
                logic [VW-1:0]        av;
                item_next[i]       = item_reg[i-1];
                item_next[i].norm  = nrm;
                item_next[i].nzero = (nrm == '0);
                item_next[i].hsq   = item_reg[i-1].hq.root;
                item_next[i].q     = '0;
                for (int l = 0; l < 3; l++) begin
                    sv = $signed(item_reg[i-1].v[l]);
                    av = (sv < 0) ? VW'(-sv) : VW'(sv);
                    item_next[i].neg[l]  = (sv < 0);
                    item_next[i].drem[l] = {av, 14'b0} + 44'(nrm >> 1);
                end
            end
        end else if (i < UST) begin : g_div
            localparam int K = 14 - (i - D0 - 1);
            always_comb begin
                logic [43:0] dv;
                item_next[i] = item_reg[i-1];
                dv = 44'(item_reg[i-1].norm) << K;
                for (int l = 0; l < 3; l++) begin
                    if (item_reg[i-1].drem[l] >= dv) begin
                        item_next[i].drem[l] = item_reg[i-1].drem[l] - dv;
                        item_next[i].q[l][K] = 1'b1;
                    end
                end
            end
        end else if (i == UST) begin : g_sign
            always_comb begin
                logic [15:0] qe;
                item_next[i] = item_reg[i-1];
                for (int l = 0; l < 3; l++) begin
                    qe = {1'b0, item_reg[i-1].q[l]};
                    if (item_reg[i-1].nzero) begin
                        item_next[i].u[l] = '0;
                    end else if (item_reg[i-1].neg[l]) begin
                        item_next[i].u[l] = -qe;
                    end else begin
                        item_next[i].u[l] = qe;
                    end
                end
            end
        end else if (i == C0) begin : g_cd_prep
            always_comb begin
                logic signed [CW-1:0] ry, rx, py, px, hy, hx;
                item_next[i] = item_reg[i-1];
                ry = CW'($signed(item_reg[i-1].ny)) <<< 16;
                rx = CW'($signed(item_reg[i-1].nz)) <<< 16;
                py = CW'($signed(item_reg[i-1].nax)) <<< 16;
                px = $signed(CW'(item_reg[i-1].hsq));
                hy = CW'($signed(item_reg[i-1].u[1])) <<< 16;
                hx = CW'($signed(item_reg[i-1].u[0])) <<< 16;
                item_next[i].cd[0] = cd_init(rx, ry);
                item_next[i].cd[1] = cd_init(px, py);
                item_next[i].cd[2] = cd_init(hx, hy);
            end
        end else if (i < BST) begin : g_cordic
            localparam int J = i - C0 - 1;
            always_comb begin
                item_next[i] = item_reg[i-1];
                for (int l = 0; l < 3; l++) begin
                    item_next[i].cd[l] = cd_step(item_reg[i-1].cd[l], J,
                                                 imucal_pkg::ATAN_TAB[J]);
                end
            end
        end else if (i == BST) begin : g_angle
            always_comb begin
                logic [31:0] hz;
                item_next[i]       = item_reg[i-1];
                item_next[i].roll  = bam16(item_reg[i-1].cd[0]);
                item_next[i].pitch = bam16(item_reg[i-1].cd[1]);
                hz = item_reg[i-1].cd[2].zero ? 32'd0 : item_reg[i-1].cd[2].z;
                item_next[i].hprod = 48'(hz) * 48'(imucal_pkg::HEADING_SCALE);
            end
        end else begin : g_heading
            always_comb begin
                logic [48:0] t;
                item_next[i] = item_reg[i-1];
                t = {1'b0, item_reg[i-1].hprod} + 49'h0_8000_0000;
                if (t[47:32] >= imucal_pkg::HEADING_SCALE) begin
                    item_next[i].heading = '0;
                end else begin
                    item_next[i].heading = t[47:32];
                end
            end
        end
    end

    for (genvar i = 0; i < LAT; i++) begin : g_pipe
        always_ff @(posedge aclk) begin
            if (adv) begin
                item_reg[i] <= item_next[i];
            end
        end
    end

    assign m_tdata = {item_reg[LAT-1].heading, item_reg[LAT-1].pitch,
                      item_reg[LAT-1].roll, item_reg[LAT-1].u[2],
                      item_reg[LAT-1].u[1], item_reg[LAT-1].u[0],
                      item_reg[LAT-1].marine[5], item_reg[LAT-1].marine[4],
                      item_reg[LAT-1].marine[3], item_reg[LAT-1].marine[2],
                      item_reg[LAT-1].marine[1], item_reg[LAT-1].marine[0]};

endmodule

[dv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES     = 16;
    localparam int SBITS      = 16;
    localparam int DRAIN      = SBITS + STAGES + 39 + 30;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_OFF   = 300;
    localparam logic [imucal_pkg::CFG_INDEX_W-1:0] UNUSED_INDEX = 3'd7;

    typedef struct packed {
        logic               pad;
        logic signed [12:0] mag_z, mag_y, mag_x;
        logic signed [15:0] rate_z, rate_y, rate_x, accel_z, accel_y, accel_x;
    } sample_t;

    typedef struct packed {
        logic [15:0] heading, pitch, roll, unit_z, unit_y, unit_x;
        logic [15:0] rate_z, rate_y, rate_x, accel_z, accel_y, accel_x;
    } marine_t;

    typedef struct {
        sample_t smp;
        bit      typed;
        marine_t res;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [imucal_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [imucal_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [135:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [191:0] m_tdata;

    logic signed [12:0] off_x, off_y, off_z;
    logic [15:0] gain_x, gain_y, gain_z;

    marine_t expected_q[$];
    int unsigned errors = 0;
    int unsigned samples_in = 0;
    int unsigned results_out = 0;
    int unsigned idle_cycles = 0;
    int unsigned config_writes = 0;

    imu_calibrate_tilt_heading #(.CORDIC_STAGES(STAGES), .SAMPLE_BITS(SBITS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned rem, root, b;
        rem = n;
        root = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic logic [31:0] vector_angle(input longint y, input longint x);
        logic [31:0] z;
        longint dx, dy;
        z = '0;
        if (x == 0 && y == 0) return '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < STAGES && i < imucal_pkg::ATAN_LEN; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (y > 0) begin
                x = x + dy;
                y = y - dx;
                z = z + imucal_pkg::ATAN_TAB[i];
            end else begin
                x = x - dy;
                y = y + dx;
                z = z - imucal_pkg::ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    function automatic logic [15:0] binary_angle(input logic [31:0] z);
        longint s;
        s = longint'($signed(z)) + 32768;
        s = s >>> 16;
        return s[15:0];
    endfunction

    function automatic logic [15:0] negate_sat(input logic signed [15:0] v);
        return (v == -16'sd32768) ? 16'sd32767 : -v;
    endfunction

    function automatic longint unit_component(input longint v, input longint unsigned norm);
        longint unsigned a;
        longint q;
        a = (v < 0) ? -v : v;
        q = (a * 16384 + norm / 2) / norm;
        return (v < 0) ? -q : q;
    endfunction

    function automatic marine_t predict_marine(input sample_t s);
        marine_t r;
        longint vx, vy, vz, ux, uy, uz, ny, nz;
        longint unsigned sq, norm, hsq, h;
        logic [31:0] hz;
        vx = (longint'(s.mag_x) - longint'(off_x)) * longint'(gain_x);
        vy = (-longint'(s.mag_y) - longint'(off_y)) * longint'(gain_y);
        vz = (longint'(s.mag_z) - longint'(off_z)) * longint'(gain_z);
        sq = vx * vx + vy * vy + vz * vz;
        norm = int_sqrt(sq);
        ux = 0;
        uy = 0;
        uz = 0;
        if (norm > 0) begin
            ux = unit_component(vx, norm);
            uy = unit_component(vy, norm);
            uz = unit_component(vz, norm);
        end
        ny = -longint'(s.accel_y);
        nz = -longint'(s.accel_z);
        r.accel_x = s.accel_x;
        r.accel_y = negate_sat(s.accel_y);
        r.accel_z = negate_sat(s.accel_z);
        r.rate_x = s.rate_x;
        r.rate_y = negate_sat(s.rate_y);
        r.rate_z = negate_sat(s.rate_z);
        r.unit_x = ux[15:0];
        r.unit_y = uy[15:0];
        r.unit_z = uz[15:0];
        r.roll = binary_angle(vector_angle(ny * 65536, nz * 65536));
        hsq = int_sqrt((ny * ny + nz * nz) << 32);
        r.pitch = binary_angle(vector_angle(-longint'(s.accel_x) * 65536, longint'(hsq)));
        hz = vector_angle(uy * 65536, ux * 65536);
        h = (longint'({32'd0, hz}) * 36000 + 64'h8000_0000) >> 32;
        if (h >= 36000) h = 0;
        r.heading = h[15:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        errors++;
        $display("MISMATCH result %0d %s: got %0d expected %0d", results_out, what, got, want);
    endtask

    task automatic write_reg(input logic [imucal_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        config_writes++;
        case (idx)
            imucal_pkg::REG_HARD_OFFSET_X: off_x = value[12:0];
            imucal_pkg::REG_HARD_OFFSET_Y: off_y = value[12:0];
            imucal_pkg::REG_HARD_OFFSET_Z: off_z = value[12:0];
            imucal_pkg::REG_SOFT_GAIN_X:   gain_x = value;
            imucal_pkg::REG_SOFT_GAIN_Y:   gain_y = value;
            imucal_pkg::REG_SOFT_GAIN_Z:   gain_z = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_sample(input sample_t s, input bit typed, input marine_t want);
        int gap;
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 9) < 3) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= s;
        do @(posedge aclk); while (!s_tready);
        expected_q.push_back(typed ? want : predict_marine(s));
        samples_in++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] draw_sample();
        case ($urandom_range(0, 7))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [12:0] draw_field13();
        case ($urandom_range(0, 9))
            0: return -13'sd4000;
            1: return 13'sd4000;
            default: return 13'($urandom_range(0, 8000) - 4000);
        endcase
    endfunction

    function automatic sample_t draw_set();
        sample_t s;
        s.pad = 1'b0;
        s.accel_x = draw_sample();
        s.accel_y = draw_sample();
        s.accel_z = draw_sample();
        s.rate_x = draw_sample();
        s.rate_y = draw_sample();
        s.rate_z = draw_sample();
        s.mag_x = draw_field13();
        s.mag_y = draw_field13();
        s.mag_z = draw_field13();
        return s;
    endfunction

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected transaction", m_tdata[15:0], 16'd0);
            end else begin
                marine_t want, got;
                want = expected_q.pop_front();
                got = m_tdata;
                if (got.accel_x !== want.accel_x) report_mismatch("accel_x", got.accel_x, want.accel_x);
                if (got.accel_y !== want.accel_y) report_mismatch("accel_y", got.accel_y, want.accel_y);
                if (got.accel_z !== want.accel_z) report_mismatch("accel_z", got.accel_z, want.accel_z);
                if (got.rate_x !== want.rate_x) report_mismatch("rate_x", got.rate_x, want.rate_x);
                if (got.rate_y !== want.rate_y) report_mismatch("rate_y", got.rate_y, want.rate_y);
                if (got.rate_z !== want.rate_z) report_mismatch("rate_z", got.rate_z, want.rate_z);
                if (got.unit_x !== want.unit_x) report_mismatch("unit_x", got.unit_x, want.unit_x);
                if (got.unit_y !== want.unit_y) report_mismatch("unit_y", got.unit_y, want.unit_y);
                if (got.unit_z !== want.unit_z) report_mismatch("unit_z", got.unit_z, want.unit_z);
                if (got.roll !== want.roll) report_mismatch("roll", got.roll, want.roll);
                if (got.pitch !== want.pitch) report_mismatch("pitch", got.pitch, want.pitch);
                if (got.heading !== want.heading) report_mismatch("heading", got.heading, want.heading);
            end
            results_out++;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles without a transaction", IDLE_LIMIT);
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        bit held;
        int stall;
        held = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!held && results_out >= 100) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF) @(posedge aclk);
            end
            stall = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        row_t rows[$];
        row_t r;
        marine_t zero_res;
        off_x = imucal_pkg::HARD_OFFSET_X_RST;
        off_y = imucal_pkg::HARD_OFFSET_Y_RST;
        off_z = imucal_pkg::HARD_OFFSET_Z_RST;
        gain_x = imucal_pkg::SOFT_GAIN_X_RST;
        gain_y = imucal_pkg::SOFT_GAIN_Y_RST;
        gain_z = imucal_pkg::SOFT_GAIN_Z_RST;
        zero_res = '0;

        r.typed = 1'b1;
        r.res = zero_res;
        r.smp = '{pad: 0, mag_x: 370, mag_y: 470, mag_z: -5, default: 0};
        rows.push_back(r);
        r.typed = 1'b0;
        r.smp = '{pad: 0, accel_y: -32768, accel_z: -32768, rate_y: -32768,
                  rate_z: -32768, default: 0};
        rows.push_back(r);
        r.smp = '{pad: 0, accel_x: 32767, accel_y: 32767, accel_z: 32767, rate_x: 32767,
                  rate_y: 32767, rate_z: 32767, mag_x: 4000, mag_y: 4000, mag_z: 4000};
        rows.push_back(r);
        r.smp = '{pad: 0, accel_x: -32768, accel_y: -32768, accel_z: -32768,
                  rate_x: -32768, mag_x: -4000, mag_y: -4000, mag_z: -4000, default: 0};
        rows.push_back(r);
        r.smp = '{pad: 0, accel_z: 16384, mag_x: -4000, mag_y: 470, mag_z: -5, default: 0};
        rows.push_back(r);
        r.smp = '{pad: 0, accel_z: -16384, mag_x: 4000, mag_y: 471, mag_z: -5, default: 0};
        rows.push_back(r);
        r.smp = '{pad: 0, accel_x: 32767, mag_x: 370, mag_y: 471, mag_z: -5, default: 0};
        rows.push_back(r);
        r.smp = '{pad: 0, accel_x: -32768, accel_y: 100, mag_x: 371, mag_y: 469,
                  mag_z: -5, default: 0};
        rows.push_back(r);
        r.smp = '{pad: 0, accel_y: -16384, mag_x: 370, mag_y: 470, mag_z: 4000, default: 0};
        rows.push_back(r);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) send_sample(rows[i].smp, rows[i].typed, rows[i].res);
        repeat (170) send_sample(draw_set(), 1'b0, zero_res);

        for (int phase = 0; phase < 5; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    write_reg(imucal_pkg::REG_HARD_OFFSET_X, -16'sd4000);
                    write_reg(imucal_pkg::REG_HARD_OFFSET_Y, 16'sd4000);
                    write_reg(imucal_pkg::REG_HARD_OFFSET_Z, -16'sd4000);
                    write_reg(imucal_pkg::REG_SOFT_GAIN_X, 16'hFFFF);
                    write_reg(imucal_pkg::REG_SOFT_GAIN_Y, 16'hFFFF);
                    write_reg(imucal_pkg::REG_SOFT_GAIN_Z, 16'hFFFF);
                end
                1: begin
                    write_reg(imucal_pkg::REG_HARD_OFFSET_X, 16'sd4000);
                    write_reg(imucal_pkg::REG_HARD_OFFSET_Y, -16'sd4000);
                    write_reg(imucal_pkg::REG_HARD_OFFSET_Z, 16'sd4000);
                    write_reg(imucal_pkg::REG_SOFT_GAIN_X, 16'd0);
                    write_reg(imucal_pkg::REG_SOFT_GAIN_Y, 16'd0);
                    write_reg(imucal_pkg::REG_SOFT_GAIN_Z, 16'd0);
                end
                default: begin
                    write_reg(UNUSED_INDEX, 16'hFFFF);
                    write_reg(imucal_pkg::REG_HARD_OFFSET_X,
                              16'($urandom_range(0, 8000) - 4000));
                    write_reg(imucal_pkg::REG_HARD_OFFSET_Y,
                              16'($urandom_range(0, 8000) - 4000));
                    write_reg(imucal_pkg::REG_HARD_OFFSET_Z,
                              16'($urandom_range(0, 8000) - 4000));
                    write_reg(imucal_pkg::REG_SOFT_GAIN_X, 16'($urandom));
                    write_reg(imucal_pkg::REG_SOFT_GAIN_Y, 16'($urandom));
                    write_reg(imucal_pkg::REG_SOFT_GAIN_Z, 16'($urandom_range(12000, 20000)));
                end
            endcase
            repeat (135) send_sample(draw_set(), 1'b0, zero_res);
        end

        wait_idle();
        $display("Sent %0d sample sets, checked %0d results over %0d register writes.",
                 samples_in, results_out, config_writes);
        $display("Covered saturating negation, zero norm, extreme offsets and gains.");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, expected_q.size());
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
